[rtl/core/qat_pkg.sv]
// Shared types and constants for the quoted argument tokenizer.
// No dependencies; every other file of the block imports this package.
package qat_pkg;

  localparam int unsigned MAX_LINE   = 256;
  localparam int unsigned MAX_TOKENS = 64;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LIMIT_W = $clog2(MAX_LINE + 1);
  localparam int unsigned POS_W   = 8;
  localparam int unsigned CNT_W   = $clog2(MAX_TOKENS + 1);
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_LINE);
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAX_LINE);
  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = LIMIT_W'(1);
  localparam logic [CNT_W-1:0]   TOKENS_MAX  = CNT_W'(MAX_TOKENS);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TEXT,
    KIND_SEP,
    KIND_TERM
  } kind_e;

  typedef struct packed {
    logic              has_bs;
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/core/qat_if.sv]
// Valid/ready channel interfaces for the tokenizer input and output beats.
// Depends on qat_pkg.
interface qat_in_if;
  import qat_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface qat_out_if;
  import qat_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic [POS_W-1:0]  out_index;
  logic              arg_start;
  logic              line_done;
  logic [CNT_W-1:0]  arg_count;
  logic              count_overflow;
  modport source (output valid, output out_char, output out_index, output arg_start,
                  output line_done, output arg_count, output count_overflow,
                  input ready);
  modport sink (input valid, input out_char, input out_index, input arg_start,
                input line_done, input arg_count, input count_overflow,
                output ready);
endinterface

[rtl/core/quoted_argument_tokenizer.sv]
// Quoted argument tokenizer: one line byte in per beat, argument buffer writes
// out, up to two output beats per input byte. The front end takes one byte per
// cycle while the queue has room and queues a command; the back end drives
// one output beat per cycle from its output register while the sink is ready,
// so a byte that flushes a held backslash with its own write takes two beats,
// one that writes nothing none, all others one. No clearing pass after reset.
// Depends on qat_pkg, qat_if, qat_front, qat_queue, qat_back.
module quoted_argument_tokenizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  qat_in_if.sink                      in_i,
  qat_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [qat_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import qat_pkg::*;

  logic      push, pop;
  cmd_t      push_cmd, head;
  q_status_t q_status;

  qat_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  qat_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  qat_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("command pushed into full queue");

  a_start_is_text : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.arg_start) |-> (out_o.out_char != CH_NUL) && !out_o.line_done)
    else $error("argument start on a zero byte");

  a_overflow_saturated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.count_overflow) |-> (out_o.arg_count == TOKENS_MAX))
    else $error("overflow flagged below token limit");

  a_pop_has_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

[rtl/core/qat_front.sv]
// Front end: accepts input bytes, tracks quote/backslash/position state and
// turns each byte into a command for the back end. Depends on qat_pkg, qat_if.
module qat_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  qat_in_if.sink                      in_i,
  input  logic                        cfg_we_i,
  input  logic [qat_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  qat_pkg::q_status_t          q_status_i,
  output logic                        push_o,
  output qat_pkg::cmd_t               push_cmd_o
);
  import qat_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               quotes_q, quotes_d;
  logic               bs_q, bs_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [LIMIT_W-1:0] lim_eff;
  logic               accept;
  logic               at_end;
  cmd_t               cmd;

  assign in_i.ready = !q_status_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    if (limit_q < LIMIT_MIN) begin
      lim_eff = LIMIT_MIN;
    end else if (limit_q > LIMIT_MAX) begin
      lim_eff = LIMIT_MAX;
    end else begin
      lim_eff = limit_q;
    end
  end

  assign at_end = {1'b0, pos_q} >= (lim_eff - LIMIT_MIN);

  always_comb begin
    cmd.has_bs = 1'b0;
    cmd.kind   = KIND_NONE;
    cmd.ch     = in_i.ch;
    quotes_d   = quotes_q;
    bs_d       = 1'b0;
    pos_d      = pos_q + POS_W'(1);
    if (at_end) begin
      cmd.has_bs = bs_q && (in_i.ch != CH_QUOTE);
      cmd.kind   = KIND_TERM;
    end else if (bs_q && (in_i.ch == CH_QUOTE)) begin
      cmd.kind = KIND_TEXT;
    end else begin
      cmd.has_bs = bs_q;
      unique case (in_i.ch)
        CH_NL, CH_NUL: cmd.kind = KIND_TERM;
        CH_SPACE, CH_TAB: cmd.kind = quotes_q ? KIND_TEXT : KIND_SEP;
        CH_BSL: bs_d = 1'b1;
        CH_QUOTE: quotes_d = !quotes_q;
        default: cmd.kind = KIND_TEXT;
      endcase
    end
    if (cmd.kind == KIND_TERM) begin
      quotes_d = 1'b0;
      bs_d     = 1'b0;
      pos_d    = '0;
    end
  end

  assign push_o     = accept && (cmd.has_bs || (cmd.kind != KIND_NONE));
  assign push_cmd_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      quotes_q <= 1'b0;
      bs_q     <= 1'b0;
      pos_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        quotes_q <= quotes_d;
        bs_q     <= bs_d;
        pos_q    <= pos_d;
      end
    end
  end

endmodule

[rtl/core/qat_queue.sv]
// Two-entry command queue between front and back end.
// Depends on qat_pkg.
module qat_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  qat_pkg::cmd_t      push_cmd_i,
  input  logic               pop_i,
  output qat_pkg::cmd_t      head_o,
  output qat_pkg::q_status_t status_o
);
  import qat_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/qat_back.sv]
// Back end: executes queued commands, tracks output position and argument
// count, and drives the registered output beats. Depends on qat_pkg, qat_if.
module qat_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qat_pkg::cmd_t      head_i,
  input  qat_pkg::q_status_t q_status_i,
  output logic               pop_o,
  qat_out_if.source          out_o
);
  import qat_pkg::*;

  logic              phase_q, phase_d;
  logic              lowz_q, lowz_d;
  logic [POS_W-1:0]  opos_q, opos_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              ovf_q, ovf_d;

  logic              ovalid_q;
  logic [CHAR_W-1:0] ochar_q, ochar_d;
  logic [POS_W-1:0]  oidx_q;
  logic              ostart_q, ostart_d;
  logic              odone_q, odone_d;
  logic [CNT_W-1:0]  ocnt_q, ocnt_d;
  logic              oovf_q, oovf_d;

  logic              can_load, fire, bs_beat;
  kind_e             beat_kind;
  logic [CHAR_W-1:0] beat_ch;

  assign can_load = !ovalid_q || out_o.ready;
  assign fire     = can_load && !q_status_i.empty;
  assign bs_beat  = !phase_q && head_i.has_bs;

  always_comb begin
    if (bs_beat) begin
      beat_kind = KIND_TEXT;
      beat_ch   = CH_BSL;
      pop_o     = fire && (head_i.kind == KIND_NONE);
      phase_d   = (head_i.kind != KIND_NONE);
    end else begin
      beat_kind = head_i.kind;
      beat_ch   = head_i.ch;
      pop_o     = fire;
      phase_d   = 1'b0;
    end
  end

  always_comb begin
    lowz_d   = lowz_q;
    opos_d   = opos_q;
    total_d  = total_q;
    ovf_d    = ovf_q;
    ochar_d  = CH_NUL;
    ostart_d = 1'b0;
    odone_d  = 1'b0;
    ocnt_d   = total_q;
    oovf_d   = ovf_q;
    case (beat_kind)
      KIND_TEXT: begin
        ochar_d  = beat_ch;
        ostart_d = lowz_q;
        if (lowz_q) begin
          if (total_q < TOKENS_MAX) begin
            total_d = total_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        ocnt_d = total_d;
        oovf_d = ovf_d;
        lowz_d = 1'b0;
        opos_d = opos_q + POS_W'(1);
      end
      KIND_SEP: begin
        lowz_d = 1'b1;
        opos_d = opos_q + POS_W'(1);
      end
      KIND_TERM: begin
        odone_d = 1'b1;
        lowz_d  = 1'b1;
        opos_d  = '0;
        total_d = '0;
        ovf_d   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ochar_q  <= ochar_d;
      oidx_q   <= opos_q;
      ostart_q <= ostart_d;
      odone_q  <= odone_d;
      ocnt_q   <= ocnt_d;
      oovf_q   <= oovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      phase_q  <= 1'b0;
      lowz_q   <= 1'b1;
      opos_q   <= '0;
      total_q  <= '0;
      ovf_q    <= 1'b0;
    end else begin
      if (can_load) begin
        ovalid_q <= fire && (beat_kind != KIND_NONE);
      end
      if (fire) begin
        phase_q <= phase_d;
        lowz_q  <= lowz_d;
        opos_q  <= opos_d;
        total_q <= total_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.out_char       = ochar_q;
  assign out_o.out_index      = oidx_q;
  assign out_o.arg_start      = ostart_q;
  assign out_o.line_done      = odone_q;
  assign out_o.arg_count      = ocnt_q;
  assign out_o.count_overflow = oovf_q;

endmodule

[dv/quoted_argument_tokenizer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for quoted_argument_tokenizer: directed table, then random and
// patterned lines under several line limits, each beat checked by table or predictor.
// Depends on qat_pkg, qat_if and the tokenizer RTL.
module quoted_argument_tokenizer_tb;
  import qat_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_CYCLES = 8;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic [POS_W-1:0]  out_index;
    logic              arg_start;
    logic              line_done;
    logic [CNT_W-1:0]  arg_count;
    logic              count_overflow;
  } write_beat_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    bit                typed;
    write_beat_t       want;
  } stim_row_t;

  typedef enum {
    GEN_MIXED,
    GEN_NO_END,
    GEN_MANY_ARGS,
    GEN_LETTERS
  } gen_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [LIMIT_W-1:0]  cfg_wdata_i;

  qat_in_if  in_ch ();
  qat_out_if out_ch ();

  quoted_argument_tokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [LIMIT_W-1:0] limit_reg;
  bit                 quoted;
  bit                 bsl_held;
  bit                 prev_zero;
  int                 in_pos;
  int                 out_pos;
  int                 tok_total;
  bit                 tok_ovf;

  write_beat_t expected_writes[$];

  int mismatches;
  int cycle_cnt;
  int bytes_sent;
  int beats_seen;
  int lines_closed;
  int ovf_lines;
  int settings_used;
  int burst_left;
  int pat_left;
  logic [7:0] stall_pat;

  stim_row_t directed_rows[23] = '{
    '{8'hFF,    1'b1, '{8'hFF, 8'd0, 1'b1, 1'b0, 7'd1, 1'b0}},
    '{CH_SPACE, 1'b1, '{CH_NUL, 8'd1, 1'b0, 1'b0, 7'd1, 1'b0}},
    '{8'h01,    1'b1, '{8'h01, 8'd2, 1'b1, 1'b0, 7'd2, 1'b0}},
    '{CH_TAB,   1'b1, '{CH_NUL, 8'd3, 1'b0, 1'b0, 7'd2, 1'b0}},
    '{CH_QUOTE, 1'b0, '0},
    '{CH_SPACE, 1'b0, '0},
    '{8'h78,    1'b0, '0},
    '{CH_QUOTE, 1'b0, '0},
    '{CH_BSL,   1'b0, '0},
    '{CH_QUOTE, 1'b0, '0},
    '{CH_BSL,   1'b0, '0},
    '{8'h79,    1'b0, '0},
    '{CH_BSL,   1'b0, '0},
    '{CH_NL,    1'b0, '0},
    '{CH_NL,    1'b1, '{CH_NUL, 8'd0, 1'b0, 1'b1, 7'd0, 1'b0}},
    '{CH_BSL,   1'b0, '0},
    '{CH_NUL,   1'b0, '0},
    '{CH_BSL,   1'b0, '0},
    '{CH_BSL,   1'b0, '0},
    '{8'h7A,    1'b0, '0},
    '{CH_QUOTE, 1'b0, '0},
    '{CH_NUL,   1'b0, '0},
    '{CH_NUL,   1'b1, '{CH_NUL, 8'd0, 1'b0, 1'b1, 7'd0, 1'b0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d writes still pending", cycle_cnt,
             expected_writes.size());
    $display("quoted_argument_tokenizer verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at beat %0d, %s: got %0d, expected %0d", beats_seen, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_line();
    quoted    = 1'b0;
    bsl_held  = 1'b0;
    prev_zero = 1'b1;
    in_pos    = 0;
    out_pos   = 0;
    tok_total = 0;
    tok_ovf   = 1'b0;
  endfunction

  function automatic void put_write(logic [CHAR_W-1:0] c, bit start, bit done);
    write_beat_t w;
    w.out_char       = c;
    w.out_index      = out_pos[POS_W-1:0];
    w.arg_start      = start;
    w.line_done      = done;
    w.arg_count      = tok_total[CNT_W-1:0];
    w.count_overflow = tok_ovf;
    expected_writes.push_back(w);
  endfunction

  function automatic void write_text(logic [CHAR_W-1:0] c);
    bit start;
    start = prev_zero;
    if (start) begin
      if (tok_total < MAX_TOKENS) tok_total++;
      else tok_ovf = 1'b1;
    end
    put_write(c, start, 1'b0);
    prev_zero = 1'b0;
    out_pos++;
  endfunction

  function automatic void write_sep();
    put_write(CH_NUL, 1'b0, 1'b0);
    prev_zero = 1'b1;
    out_pos++;
  endfunction

  function automatic void write_term();
    put_write(CH_NUL, 1'b0, 1'b1);
    clear_line();
  endfunction

  function automatic void split_byte(logic [CHAR_W-1:0] c);
    int lim;
    lim = int'(limit_reg);
    if (lim < 1) lim = 1;
    if (lim > MAX_LINE) lim = MAX_LINE;
    if (in_pos >= lim - 1) begin
      if (bsl_held && c != CH_QUOTE) write_text(CH_BSL);
      write_term();
      return;
    end
    if (bsl_held) begin
      bsl_held = 1'b0;
      if (c == CH_QUOTE) begin
        write_text(CH_QUOTE);
        in_pos++;
        return;
      end
      write_text(CH_BSL);
    end
    case (c)
      CH_NL, CH_NUL: begin
        write_term();
        return;
      end
      CH_SPACE, CH_TAB: begin
        if (quoted) write_text(c);
        else write_sep();
      end
      CH_BSL: bsl_held = 1'b1;
      CH_QUOTE: quoted = !quoted;
      default: write_text(c);
    endcase
    in_pos++;
  endfunction

  function automatic logic [CHAR_W-1:0] next_byte(gen_mode_e mode, int i);
    int roll;
    if (mode == GEN_LETTERS) return 8'h61 + 8'(i % 26);
    if (mode == GEN_MANY_ARGS) begin
      if (i >= 140) return CH_NL;
      return (i % 2) ? CH_SPACE : 8'h61 + 8'((i / 2) % 26);
    end
    roll = $urandom_range(0, 99);
    if (roll < 30) return 8'($urandom_range(8'h61, 8'h7A));
    if (roll < 42) return CH_SPACE;
    if (roll < 47) return CH_TAB;
    if (roll < 57) return CH_QUOTE;
    if (roll < 67) return CH_BSL;
    if (roll < 71) return (mode == GEN_NO_END) ? 8'h71 : CH_NL;
    if (roll < 73) return (mode == GEN_NO_END) ? 8'h72 : CH_NUL;
    roll = $urandom_range(0, 255);
    if (mode == GEN_NO_END && (roll == CH_NL || roll == CH_NUL)) roll = 8'h80;
    return 8'(roll);
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] b, input bit typed, input write_beat_t want);
    int gap;
    int n0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.ch    = b;
    do @(posedge clk_i); while (!in_ch.ready);
    n0 = expected_writes.size();
    split_byte(b);
    if (typed) begin
      while (expected_writes.size() > n0) void'(expected_writes.pop_back());
      expected_writes.push_back(want);
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (expected_writes.size() != 0) @(negedge clk_i);
    repeat (IDLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    limit_reg = v;
    settings_used++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_phase(input int lim, input int count, input gen_mode_e mode);
    write_limit(LIMIT_W'(lim));
    for (int i = 0; i < count; i++) begin
      if (count >= 100 && i == count / 2) drain();
      send_byte(next_byte(mode, i), 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (pat_left == 0) begin
      pat_left  = 32;
      stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
      if (stall_pat == 8'h00) stall_pat = 8'h01;
    end
    out_ch.ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[7:1]};
    pat_left--;
  end

  always @(posedge clk_i) begin
    write_beat_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected beat, out_char", out_ch.out_char, -1);
      end else begin
        w = expected_writes.pop_front();
        if (out_ch.out_char != w.out_char)
          report_mismatch("out_char", out_ch.out_char, w.out_char);
        if (out_ch.out_index != w.out_index)
          report_mismatch("out_index", out_ch.out_index, w.out_index);
        if (out_ch.arg_start !== w.arg_start)
          report_mismatch("arg_start", out_ch.arg_start, w.arg_start);
        if (out_ch.line_done !== w.line_done)
          report_mismatch("line_done", out_ch.line_done, w.line_done);
        if (out_ch.arg_count != w.arg_count)
          report_mismatch("arg_count", out_ch.arg_count, w.arg_count);
        if (out_ch.count_overflow !== w.count_overflow)
          report_mismatch("count_overflow", out_ch.count_overflow, w.count_overflow);
        if (w.line_done) lines_closed++;
        if (w.line_done && w.count_overflow) ovf_lines++;
      end
      beats_seen++;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_ch.valid  = 1'b0;
    in_ch.ch     = '0;
    out_ch.ready = 1'b0;
    cycle_cnt    = 0;
    mismatches   = 0;
    bytes_sent   = 0;
    beats_seen   = 0;
    lines_closed = 0;
    ovf_lines    = 0;
    settings_used = 0;
    burst_left   = 0;
    pat_left     = 0;
    stall_pat    = 8'hFF;
    limit_reg    = LIMIT_RESET;
    clear_line();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);

    run_phase(256, 150, GEN_MIXED);
    run_phase(256, 145, GEN_MANY_ARGS);
    run_phase(511, 300, GEN_NO_END);
    run_phase(1, 30, GEN_MIXED);
    run_phase(0, 30, GEN_MIXED);
    run_phase(2, 60, GEN_MIXED);
    run_phase(3, 60, GEN_MIXED);
    run_phase(256, 20, GEN_LETTERS);
    run_phase(4, 40, GEN_MIXED);
    run_phase($urandom_range(5, 40), 100, GEN_MIXED);
    run_phase($urandom_range(1, 256), 100, GEN_MIXED);
    run_phase(256, 50, GEN_MIXED);

    drain();
    if (expected_writes.size() != 0)
      report_mismatch("writes left pending", expected_writes.size(), 0);

    $display("sent %0d bytes under %0d line_limit settings, checked %0d output beats",
             bytes_sent, settings_used, beats_seen);
    $display("closed %0d lines, %0d of them past the argument limit", lines_closed, ovf_lines);
    if (mismatches == 0) begin
      $display("quoted_argument_tokenizer verification clean");
    end else begin
      $display("quoted_argument_tokenizer verification failed");
    end
    $finish;
  end

endmodule
